>>> src/bsirq_pkg.sv
package bsirq_pkg;

    // Request type codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_PAGES = 2'd0;
    localparam logic [1:0] CFG_CHR_PAGES = 2'd1;

    // Register addresses
    localparam logic [15:0] ADDR_PRG_16K  = 16'h8000;
    localparam logic [15:0] ADDR_MIRROR   = 16'hB003;
    localparam logic [15:0] ADDR_PRG_8K   = 16'hC000;
    localparam logic [15:0] ADDR_CHR_LOW  = 16'hD000;
    localparam logic [15:0] ADDR_CHR_HIGH = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_LAT  = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_CTL  = 16'hF001;
    localparam logic [15:0] ADDR_IRQ_ACK  = 16'hF002;

    // IRQ control bits and counter overflow value
    localparam int unsigned   CTL_REARM  = 0;
    localparam int unsigned   CTL_ENABLE = 1;
    localparam logic [7:0]    IRQ_TOP    = 8'hFF;

    // Slot bases
    localparam logic [3:0] SLOT_PRG0     = 4'd0;
    localparam logic [3:0] SLOT_PRG2     = 4'd2;
    localparam logic [3:0] SLOT_CHR_LOW  = 4'd4;
    localparam logic [3:0] SLOT_CHR_HIGH = 4'd8;

    // Reset page counts
    localparam logic [9:0]  PRG_PAGES_RESET = 10'd2;
    localparam logic [11:0] CHR_PAGES_RESET = 12'd8;

    localparam int unsigned PAGE_W = 9;
    localparam int unsigned CFG_W  = 12;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
    } in_t;

    typedef struct packed {
        logic              irq_fire;
        logic [1:0]        mirror_mode;
        logic              bank_valid;
        logic [3:0]        bank_slot;
        logic [PAGE_W-1:0] bank_page;
        logic              last_result;
    } out_t;

endpackage

>>> src/bank_switch_and_scanline_irq.sv
// Channel   | Ports                         | Request moved
// ----------+-------------------------------+-----------------------------------
// input     | s_valid s_ready s_payload     | init, register write or tick
// result    | m_valid m_ready m_payload     | one slot mapping or status word
// config    | cfg_wr_en cfg_index cfg_wdata | page count write, no wait
//
// Status result (tick, mirror, IRQ, unmapped or unused request): accept,
// then load. Init loads its four slots back to back unless the output stalls.
// A banked write runs a restoring modulo, one dividend bit per cycle, then
// loads; the second 0x8000 result runs the modulo again and loads once more.
// A new request is taken only when the sequencer is idle; a stalled output
// register holds the sequencer in its load state. Reset is synchronous.
module bank_switch_and_scanline_irq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bsirq_pkg::in_t   s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output bsirq_pkg::out_t  m_payload,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [bsirq_pkg::CFG_W-1:0] cfg_wdata
);
    import bsirq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t      state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_payload_reg, m_payload_next;

    logic [9:0]  prg_pages_reg, prg_pages_next;
    logic [11:0] chr_pages_reg, chr_pages_next;
    logic [7:0]  irq_counter_reg, irq_counter_next;
    logic [7:0]  irq_reload_reg, irq_reload_next;
    logic [1:0]  irq_control_reg, irq_control_next;
    logic [1:0]  mirror_reg, mirror_next;

    // Job registers for the request in progress
    logic        init_reg, init_next;
    logic        use_mod_reg, use_mod_next;
    logic        bank_reg, bank_next;
    logic        fire_reg, fire_next;
    logic [3:0]  slot_base_reg, slot_base_next;
    logic [1:0]  last_idx_reg, last_idx_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  data_reg, data_next;

    // Shared divider
    logic [11:0] divisor_reg, divisor_next;
    logic [PAGE_W-1:0] dividend_reg, dividend_next;
    logic [11:0] rem_reg, rem_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [12:0] trial;
    logic [13:0] diff;

    logic        accept;
    logic        out_free;
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [PAGE_W-1:0] load_page;
    logic [9:0]  prg_minus;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign req_type = s_payload.req_type;
    assign addr     = s_payload.bus_addr;
    assign data     = s_payload.bus_data;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dividend_reg[PAGE_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor_reg};

    // Init pages count-2 and count-1, cut to page width
    assign prg_minus = prg_pages_reg - {8'd0, ~idx_reg[0], idx_reg[0]};

    // Pick the page of the result being loaded
    always_comb begin
        if (init_reg) begin
            if (idx_reg[1]) begin
                load_page = prg_minus[PAGE_W-1:0];
            end else begin
                load_page = {{(PAGE_W-1){1'b0}}, idx_reg[0]};
            end
        end else if (use_mod_reg && (divisor_reg != 12'd0)) begin
            load_page = rem_reg[PAGE_W-1:0];
        end else begin
            load_page = '0;
        end
    end

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        m_payload_next   = m_payload_reg;
        prg_pages_next   = prg_pages_reg;
        chr_pages_next   = chr_pages_reg;
        irq_counter_next = irq_counter_reg;
        irq_reload_next  = irq_reload_reg;
        irq_control_next = irq_control_reg;
        mirror_next      = mirror_reg;
        init_next        = init_reg;
        use_mod_next     = use_mod_reg;
        bank_next        = bank_reg;
        fire_next        = fire_reg;
        slot_base_next   = slot_base_reg;
        last_idx_next    = last_idx_reg;
        idx_next         = idx_reg;
        data_next        = data_reg;
        divisor_next     = divisor_reg;
        dividend_next    = dividend_reg;
        rem_next         = rem_reg;
        bit_cnt_next     = bit_cnt_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Write page counts
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRG_PAGES: prg_pages_next = cfg_wdata[9:0];
                CFG_CHR_PAGES: chr_pages_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    init_next      = 1'b0;
                    use_mod_next   = 1'b0;
                    bank_next      = 1'b0;
                    fire_next      = 1'b0;
                    slot_base_next = SLOT_PRG0;
                    last_idx_next  = 2'd0;
                    idx_next       = 2'd0;
                    data_next      = data;
                    divisor_next   = {2'b00, prg_pages_reg};
                    dividend_next  = {1'b0, data};
                    rem_next       = '0;
                    bit_cnt_next   = '0;

                    // Decode the request and apply its state updates
                    if (req_type == REQ_INIT) begin
                        init_next     = 1'b1;
                        bank_next     = 1'b1;
                        last_idx_next = 2'd3;
                    end else if (req_type == REQ_TICK) begin
                        if (irq_control_reg[CTL_ENABLE]) begin
                            if (irq_counter_reg == IRQ_TOP) begin
                                fire_next        = 1'b1;
                                irq_counter_next = irq_reload_reg;
                            end else begin
                                irq_counter_next = irq_counter_reg + 8'd1;
                            end
                        end
                    end else if (req_type == REQ_WRITE) begin
                        if (addr == ADDR_PRG_16K) begin
                            use_mod_next  = 1'b1;
                            bank_next     = 1'b1;
                            last_idx_next = 2'd1;
                        end else if (addr == ADDR_PRG_8K) begin
                            use_mod_next   = 1'b1;
                            bank_next      = 1'b1;
                            slot_base_next = SLOT_PRG2;
                        end else if (addr[15:2] == ADDR_CHR_LOW[15:2]) begin
                            use_mod_next   = 1'b1;
                            bank_next      = 1'b1;
                            slot_base_next = SLOT_CHR_LOW | {2'b00, addr[1:0]};
                            divisor_next   = chr_pages_reg;
                        end else if (addr[15:2] == ADDR_CHR_HIGH[15:2]) begin
                            use_mod_next   = 1'b1;
                            bank_next      = 1'b1;
                            slot_base_next = SLOT_CHR_HIGH | {2'b00, addr[1:0]};
                            divisor_next   = chr_pages_reg;
                        end else if (addr == ADDR_MIRROR) begin
                            mirror_next = data[3:2];
                        end else if (addr == ADDR_IRQ_LAT) begin
                            irq_reload_next = data;
                        end else if (addr == ADDR_IRQ_CTL) begin
                            irq_control_next = data[1:0];
                            if (data[CTL_ENABLE]) begin
                                irq_counter_next = irq_reload_reg;
                            end
                        end else if (addr == ADDR_IRQ_ACK) begin
                            irq_control_next = {2{irq_control_reg[CTL_REARM]}};
                        end
                    end

                    if ((req_type == REQ_WRITE) &&
                        ((addr == ADDR_PRG_16K) || (addr == ADDR_PRG_8K) ||
                         (addr[15:2] == ADDR_CHR_LOW[15:2]) ||
                         (addr[15:2] == ADDR_CHR_HIGH[15:2]))) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_DIV: begin
                // Advance the modulo by one bit
                rem_next      = diff[13] ? trial[11:0] : diff[11:0];
                dividend_next = {dividend_reg[PAGE_W-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + 4'd1;
                if (bit_cnt_reg == 4'(PAGE_W - 1)) begin
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.irq_fire    = fire_reg;
                    m_payload_next.mirror_mode = mirror_reg;
                    m_payload_next.bank_valid  = bank_reg;
                    m_payload_next.bank_slot   = bank_reg ?
                        (slot_base_reg + {2'b00, idx_reg}) : 4'd0;
                    m_payload_next.bank_page   = load_page;
                    m_payload_next.last_result = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                        if (use_mod_reg) begin
                            dividend_next = {1'b0, data_reg} + {{(PAGE_W-2){1'b0}}, idx_next};
                            rem_next      = '0;
                            bit_cnt_next  = '0;
                            state_next    = ST_DIV;
                        end
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            prg_pages_reg   <= PRG_PAGES_RESET;
            chr_pages_reg   <= CHR_PAGES_RESET;
            irq_counter_reg <= '0;
            irq_reload_reg  <= '0;
            irq_control_reg <= '0;
            mirror_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            prg_pages_reg   <= prg_pages_next;
            chr_pages_reg   <= chr_pages_next;
            irq_counter_reg <= irq_counter_next;
            irq_reload_reg  <= irq_reload_next;
            irq_control_reg <= irq_control_next;
            mirror_reg      <= mirror_next;
        end
        m_payload_reg <= m_payload_next;
        init_reg      <= init_next;
        use_mod_reg   <= use_mod_next;
        bank_reg      <= bank_next;
        fire_reg      <= fire_next;
        slot_base_reg <= slot_base_next;
        last_idx_reg  <= last_idx_next;
        idx_reg       <= idx_next;
        data_reg      <= data_next;
        divisor_reg   <= divisor_next;
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
    end

    // An accepted request keeps the sequencer busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("sequencer ready right after an accept");

    // An interrupt only rides on a status result, which is also the last
    a_fire_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.irq_fire) |->
            (!m_payload_reg.bank_valid && m_payload_reg.last_result))
        else $error("interrupt on a bank result");

    // Mapped slots stay within the twelve slots
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.bank_valid) |->
            (m_payload_reg.bank_slot <= 4'd11))
        else $error("bank slot out of range");

    // Character pages come out reduced below the character page count
    a_chr_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.bank_valid &&
         (m_payload_reg.bank_slot >= SLOT_CHR_LOW) && (chr_pages_reg != 12'd0)) |->
            ({3'b000, m_payload_reg.bank_page} < chr_pages_reg))
        else $error("character page not reduced");

    // The divider finishes its pass before a result is loaded from it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV) && (state_next == ST_LOAD)) |->
            (bit_cnt_reg == 4'(PAGE_W - 1)))
        else $error("modulo left early");

endmodule

>>> tb/tb_bank_switch_and_scanline_irq.sv
module tb_bank_switch_and_scanline_irq;
    import bsirq_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_TIME    = 8000000;
    localparam int PRINT_CAP     = 50;

    // Request type the block does not define
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    in_t            s_payload = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    out_t           m_payload;
    logic           cfg_wr_en = 1'b0;
    logic [1:0]     cfg_index = CFG_PRG_PAGES;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Mapper state as the block should hold it
    logic [9:0]  prg_pages    = PRG_PAGES_RESET;
    logic [11:0] chr_pages    = CHR_PAGES_RESET;
    logic [7:0]  scan_counter = 8'd0;
    logic [7:0]  scan_latch   = 8'd0;
    logic [1:0]  irq_ctl      = 2'd0;
    logic [1:0]  mirror_now   = 2'd0;

    out_t due_mappings[$];

    bit source_stalls = 1'b1;
    bit sink_stalls   = 1'b1;
    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int interrupts_seen = 0;
    int settings_done   = 0;

    bank_switch_and_scanline_irq u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Toggle the clock
    always #HALF_PERIOD aclk = ~aclk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Reduce a byte to a page; a zero count maps everything to page 0
    function automatic logic [8:0] reduce_page(input logic [8:0] value,
                                               input logic [11:0] count);
        int unsigned v;
        int unsigned c;
        int unsigned r;
        v = {23'b0, value};
        c = {20'b0, count};
        if (c == 0) begin
            return 9'd0;
        end
        r = v % c;
        return r[8:0];
    endfunction

    // Queue one expected result with the mirroring as it stands now
    function automatic void queue_mapping(input logic fire, input logic valid,
                                          input logic [3:0] slot, input logic [8:0] page,
                                          input logic last);
        out_t r;
        r.irq_fire    = fire;
        r.mirror_mode = mirror_now;
        r.bank_valid  = valid;
        r.bank_slot   = valid ? slot : 4'd0;
        r.bank_page   = valid ? page : 9'd0;
        r.last_result = last;
        due_mappings.push_back(r);
    endfunction

    // Advance the mapper state for one request and queue its results
    function automatic void predict_mapping(input in_t item);
        logic [9:0] prg_minus_two;
        logic [9:0] prg_minus_one;
        logic [8:0] next_byte;
        logic       fire;
        prg_minus_two = prg_pages - 10'd2;
        prg_minus_one = prg_pages - 10'd1;
        next_byte     = {1'b0, item.bus_data} + 9'd1;
        fire          = 1'b0;
        case (item.req_type)
            REQ_INIT: begin
                queue_mapping(1'b0, 1'b1, SLOT_PRG0, 9'd0, 1'b0);
                queue_mapping(1'b0, 1'b1, SLOT_PRG0 + 4'd1, 9'd1, 1'b0);
                queue_mapping(1'b0, 1'b1, SLOT_PRG2, prg_minus_two[8:0], 1'b0);
                queue_mapping(1'b0, 1'b1, SLOT_PRG2 + 4'd1, prg_minus_one[8:0], 1'b1);
            end
            REQ_TICK: begin
                if (irq_ctl[CTL_ENABLE]) begin
                    if (scan_counter == IRQ_TOP) begin
                        fire         = 1'b1;
                        scan_counter = scan_latch;
                    end else begin
                        scan_counter = scan_counter + 8'd1;
                    end
                end
                queue_mapping(fire, 1'b0, 4'd0, 9'd0, 1'b1);
            end
            REQ_WRITE: begin
                if (item.bus_addr == ADDR_PRG_16K) begin
                    queue_mapping(1'b0, 1'b1, SLOT_PRG0,
                                  reduce_page({1'b0, item.bus_data}, {2'b0, prg_pages}), 1'b0);
                    queue_mapping(1'b0, 1'b1, SLOT_PRG0 + 4'd1,
                                  reduce_page(next_byte, {2'b0, prg_pages}), 1'b1);
                end else if (item.bus_addr == ADDR_PRG_8K) begin
                    queue_mapping(1'b0, 1'b1, SLOT_PRG2,
                                  reduce_page({1'b0, item.bus_data}, {2'b0, prg_pages}), 1'b1);
                end else if (item.bus_addr[15:2] == ADDR_CHR_LOW[15:2]) begin
                    queue_mapping(1'b0, 1'b1, SLOT_CHR_LOW + {2'b0, item.bus_addr[1:0]},
                                  reduce_page({1'b0, item.bus_data}, chr_pages), 1'b1);
                end else if (item.bus_addr[15:2] == ADDR_CHR_HIGH[15:2]) begin
                    queue_mapping(1'b0, 1'b1, SLOT_CHR_HIGH + {2'b0, item.bus_addr[1:0]},
                                  reduce_page({1'b0, item.bus_data}, chr_pages), 1'b1);
                end else begin
                    if (item.bus_addr == ADDR_MIRROR) begin
                        mirror_now = item.bus_data[3:2];
                    end else if (item.bus_addr == ADDR_IRQ_LAT) begin
                        scan_latch = item.bus_data;
                    end else if (item.bus_addr == ADDR_IRQ_CTL) begin
                        irq_ctl = item.bus_data[1:0];
                        if (irq_ctl[CTL_ENABLE]) begin
                            scan_counter = scan_latch;
                        end
                    end else if (item.bus_addr == ADDR_IRQ_ACK) begin
                        irq_ctl[CTL_ENABLE] = irq_ctl[CTL_REARM];
                    end
                    queue_mapping(1'b0, 1'b0, 4'd0, 9'd0, 1'b1);
                end
            end
            default: begin
                queue_mapping(1'b0, 1'b0, 4'd0, 9'd0, 1'b1);
            end
        endcase
    endfunction

    function automatic in_t make_request(input logic [1:0] kind, input logic [15:0] addr,
                                         input logic [7:0] data);
        in_t r;
        r.req_type = kind;
        r.bus_addr = addr;
        r.bus_data = data;
        return r;
    endfunction

    // Send one request; valid stays high after acceptance so back-to-back
    // requests need no extra edge. Caller runs on a rising edge.
    task automatic send_request(input in_t item);
        if (source_stalls && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_payload <= item;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mapping(item);
        requests_sent++;
    endtask

    // Drop valid and hold until every queued result has arrived
    task automatic wait_until_drained(input int extra);
        s_valid <= 1'b0;
        while (due_mappings.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Write a page count while the block is idle
    task automatic write_page_count(input logic [1:0] index, input logic [CFG_W-1:0] value);
        wait_until_drained(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_PRG_PAGES) begin
            prg_pages = value[9:0];
        end else if (index == CFG_CHR_PAGES) begin
            chr_pages = value[11:0];
        end
        settings_done++;
    endtask

    // Mostly well-formed mapper traffic with random content, some noise
    function automatic in_t random_request();
        in_t r;
        logic [31:0] roll;
        int unsigned pick;
        roll = $urandom();
        r.req_type = REQ_WRITE;
        r.bus_addr = roll[15:0];
        r.bus_data = roll[23:16];
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.req_type = REQ_INIT;
        end else if (pick < 40) begin
            r.req_type = REQ_TICK;
        end else if (pick < 42) begin
            r.req_type = REQ_UNUSED;
        end else if (pick < 52) begin
            r.bus_addr = ADDR_PRG_16K;
        end else if (pick < 58) begin
            r.bus_addr = ADDR_PRG_8K;
        end else if (pick < 66) begin
            r.bus_addr = ADDR_CHR_LOW + {14'b0, roll[25:24]};
        end else if (pick < 74) begin
            r.bus_addr = ADDR_CHR_HIGH + {14'b0, roll[25:24]};
        end else if (pick < 78) begin
            r.bus_addr = ADDR_MIRROR;
        end else if (pick < 83) begin
            // keep the latch near the top so overflows come often
            r.bus_addr = ADDR_IRQ_LAT;
            if (roll[26]) begin
                r.bus_data = {4'hF, roll[19:16]};
            end
        end else if (pick < 89) begin
            r.bus_addr = ADDR_IRQ_CTL;
        end else if (pick < 95) begin
            r.bus_addr = ADDR_IRQ_ACK;
        end else if (pick < 97) begin
            // near misses around the decoded ranges
            r.bus_addr = roll[27] ? ADDR_CHR_LOW + 16'd4 : ADDR_PRG_16K + 16'd1;
        end
        return r;
    endfunction

    task automatic run_traffic_phase(input logic [CFG_W-1:0] prg, input logic [CFG_W-1:0] chr,
                                     input int count, input bit stalls);
        write_page_count(CFG_PRG_PAGES, prg);
        write_page_count(CFG_CHR_PAGES, chr);
        source_stalls = stalls;
        sink_stalls   = stalls;
        for (int i = 0; i < count; i++) begin
            send_request(random_request());
        end
    endtask

    task automatic test_bank_init();
        send_request(make_request(REQ_INIT, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_program_banks();
        send_request(make_request(REQ_WRITE, ADDR_PRG_16K, 8'h00));
        send_request(make_request(REQ_WRITE, ADDR_PRG_16K, 8'hFF));
        send_request(make_request(REQ_WRITE, ADDR_PRG_8K, 8'hFF));
    endtask

    task automatic test_character_banks();
        send_request(make_request(REQ_WRITE, ADDR_CHR_LOW, 8'h00));
        send_request(make_request(REQ_WRITE, ADDR_CHR_LOW + 16'd3, 8'hFF));
        send_request(make_request(REQ_WRITE, ADDR_CHR_HIGH, 8'h80));
        send_request(make_request(REQ_WRITE, ADDR_CHR_HIGH + 16'd3, 8'hFF));
    endtask

    task automatic test_mirroring();
        send_request(make_request(REQ_WRITE, ADDR_MIRROR, 8'h0C));
        send_request(make_request(REQ_WRITE, ADDR_MIRROR, 8'h08));
        send_request(make_request(REQ_WRITE, ADDR_MIRROR, 8'h04));
        send_request(make_request(REQ_WRITE, ADDR_MIRROR, 8'h03));
    endtask

    // Count up to overflow, reload, then acknowledge with and without re-arm
    task automatic test_scanline_irq();
        send_request(make_request(REQ_WRITE, ADDR_IRQ_LAT, 8'hFD));
        send_request(make_request(REQ_WRITE, ADDR_IRQ_CTL, 8'h03));
        repeat (3) send_request(make_request(REQ_TICK, 16'h0000, 8'h00));
        send_request(make_request(REQ_WRITE, ADDR_IRQ_ACK, 8'h00));
        send_request(make_request(REQ_WRITE, ADDR_IRQ_CTL, 8'h02));
        send_request(make_request(REQ_WRITE, ADDR_IRQ_ACK, 8'h00));
        send_request(make_request(REQ_TICK, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_ignored_requests();
        send_request(make_request(REQ_UNUSED, 16'hFFFF, 8'hFF));
        send_request(make_request(REQ_WRITE, 16'h0000, 8'h00));
        send_request(make_request(REQ_WRITE, ADDR_CHR_LOW + 16'd4, 8'h55));
        send_request(make_request(REQ_WRITE, ADDR_IRQ_ACK + 16'd1, 8'hAA));
    endtask

    task automatic test_random_traffic();
        logic [31:0] prg;
        logic [31:0] chr;
        run_traffic_phase(12'd0, 12'd0, 50, 1'b1);
        run_traffic_phase(12'd1, 12'd1, 50, 1'b1);
        run_traffic_phase(12'd512, 12'd2048, 25, 1'b1);
        // pause the sender mid-phase until everything has come back
        wait_until_drained(SETTLE_CYCLES);
        for (int i = 0; i < 25; i++) begin
            send_request(random_request());
        end
        run_traffic_phase(12'hFFF, 12'hFFF, 50, 1'b1);
        run_traffic_phase({2'b00, PRG_PAGES_RESET}, CHR_PAGES_RESET, 50, 1'b0);
        for (int p = 0; p < 2; p++) begin
            prg = $urandom_range(2, 512);
            chr = $urandom_range(1, 2048);
            run_traffic_phase(prg[CFG_W-1:0], chr[CFG_W-1:0], 50, 1'b1);
        end
        // final stretch runs at full rate
        prg = $urandom_range(2, 512);
        chr = $urandom_range(1, 2048);
        run_traffic_phase(prg[CFG_W-1:0], chr[CFG_W-1:0], 60, 1'b0);
    endtask

    // Stall the result side in random bursts
    always begin
        @(posedge aclk);
        if (sink_stalls && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (m_payload.irq_fire) begin
                interrupts_seen++;
            end
            if (due_mappings.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(m_payload), 32'd0);
            end else begin
                want = due_mappings.pop_front();
                if (m_payload.irq_fire != want.irq_fire)
                    report_mismatch("irq_fire", 32'(m_payload.irq_fire),
                                    32'(want.irq_fire));
                if (m_payload.mirror_mode != want.mirror_mode)
                    report_mismatch("mirror_mode", 32'(m_payload.mirror_mode),
                                    32'(want.mirror_mode));
                if (m_payload.bank_valid != want.bank_valid)
                    report_mismatch("bank_valid", 32'(m_payload.bank_valid),
                                    32'(want.bank_valid));
                if (m_payload.bank_slot != want.bank_slot)
                    report_mismatch("bank_slot", 32'(m_payload.bank_slot),
                                    32'(want.bank_slot));
                if (m_payload.bank_page != want.bank_page)
                    report_mismatch("bank_page", 32'(m_payload.bank_page),
                                    32'(want.bank_page));
                if (m_payload.last_result != want.last_result)
                    report_mismatch("last_result", 32'(m_payload.last_result),
                                    32'(want.last_result));
            end
        end
    end

    // End a hung run
    initial begin
        #LIMIT_TIME;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_bank_init();
        test_program_banks();
        test_character_banks();
        test_mirroring();
        test_scanline_irq();
        test_ignored_requests();
        test_random_traffic();
        wait_until_drained(DRAIN_CYCLES);
        if (due_mappings.size() != 0) begin
            report_mismatch("results never delivered", 32'd0, 32'(due_mappings.size()));
        end
        $display("covered %0d requests over %0d page count settings", requests_sent,
                 settings_done);
        $display("checked %0d results, %0d of them interrupts", results_checked,
                 interrupts_seen);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
